### src/ecda_pkg.sv
// shared types, constants and field positions of the error counter delta accumulator
package ecda_pkg;

  localparam int MAX_SLAVES_DEF = 64;
  localparam int TOTAL_BITS_DEF = 32;
  localparam int BLOCK_BYTES    = 20;

  localparam int SLAVE_W  = 6;
  localparam int IDX_W    = 5;
  localparam int VAL_W    = 8;
  localparam int DELTA_W  = 8;
  localparam int OUT_W    = 32;
  localparam int EVENT_W  = 32;
  localparam int SCOUNT_W = 7;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // input tdata: slave_index, counter_index, counter_value
  localparam int IN_IDX_LSB = SLAVE_W;
  localparam int IN_VAL_LSB = SLAVE_W + IDX_W;
  localparam int IN_TDATA_W = 24;

  // output tdata: delta, total, block_saturated, saturation_events
  localparam int OUT_TOTAL_LSB = DELTA_W;
  localparam int OUT_FLAG_BIT  = DELTA_W + OUT_W;
  localparam int OUT_EVT_LSB   = OUT_FLAG_BIT + 1;
  localparam int OUT_USED_W    = OUT_EVT_LSB + EVENT_W;
  localparam int OUT_TDATA_W   = 80;

  localparam logic [VAL_W-1:0]    FF_VALUE        = 8'hFF;
  localparam logic [IDX_W-1:0]    IDX_STATUS_LO   = 5'd14;
  localparam logic [IDX_W-1:0]    IDX_STATUS_HI   = 5'd15;
  localparam logic [SCOUNT_W-1:0] SLAVE_COUNT_RST = 7'd64;

  typedef enum logic {
    REG_AUTO_CLEAR  = 1'b0,
    REG_SLAVE_COUNT = 1'b1
  } reg_e;

  function automatic logic counts_errors(input logic [IDX_W-1:0] idx);
    return (int'(idx) < BLOCK_BYTES) && (idx != IDX_STATUS_LO) && (idx != IDX_STATUS_HI);
  endfunction

endpackage

### src/ecda_ram.sv
// generic single write port ram with registered read
module ecda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/error_counter_delta_accumulator_top.sv
// top level of the error counter delta accumulator
//
// Input stream: one request per counter byte of a slave's diagnostic block,
// tlast on the final byte. Output stream: one result per request whose slave
// lies below slave_count, carrying the increase, the running total of that
// slave and byte, the block saturation flag and the per-slave flagged-block
// count. Requests for slaves outside the configured range are taken and
// dropped without a result.
// The ram reads are taken and the update stage is loaded at the input
// handshake; the update fills the result register when the stage advances.
// Throughput is one request per cycle while the receiver is not stalling;
// back-to-back hits on the same cell are forwarded from the write stage, so
// no bubble is needed. After reset the block sweeps the totals memory and
// the per-slave memory (flagged-block counts and previous-block marks) to
// zero, one entry per cycle; s_axis_tready stays low until it is done.
// Configuration writes are taken at any time but are meant for an idle block.
// When the receiver stalls, the result register holds and the update stage
// keeps one more request, after which s_axis_tready drops.
module error_counter_delta_accumulator_top
  import ecda_pkg::*;
#(
  parameter int MAX_SLAVES = MAX_SLAVES_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [5:0] slave_index, [10:6] counter_index, [18:11] counter_value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] delta, [39:8] total, [40] block_saturated, [72:41] saturation_events
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int CELLS   = MAX_SLAVES * BLOCK_BYTES;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SLV_AW  = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [EVENT_W-1:0]    EVENT_MAX = '1;

  // configuration
  logic                cor_q;
  logic [SCOUNT_W-1:0] slave_count_q;
  logic                cfg_wr;
  reg_e                cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_reg = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_q         <= 1'b0;
      slave_count_q <= SLAVE_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_AUTO_CLEAR:  cor_q         <= pwdata[0];
        REG_SLAVE_COUNT: slave_count_q <= pwdata[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_AUTO_CLEAR:  prdata = {{(APB_DW-1){1'b0}}, cor_q};
      REG_SLAVE_COUNT: prdata = {{(APB_DW-SCOUNT_W){1'b0}}, slave_count_q};
      default:         prdata = '0;
    endcase
  end

  // clearing sweep after reset
  logic               clr_busy_q;
  logic [CELL_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (int'(clr_cnt_q) == CELLS - 1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // input side
  logic [SLAVE_W-1:0] in_slave;
  logic [IDX_W-1:0]   in_idx;
  logic [VAL_W-1:0]   in_val;
  logic               in_hs;
  logic               in_keep;
  logic               in_load;
  logic [CELL_AW-1:0] in_cell;
  logic [SLV_AW-1:0]  in_slv;

  assign in_slave = s_axis_tdata[SLAVE_W-1:0];
  assign in_idx   = s_axis_tdata[IN_IDX_LSB +: IDX_W];
  assign in_val   = s_axis_tdata[IN_VAL_LSB +: VAL_W];
  assign in_hs    = s_axis_tvalid & s_axis_tready;
  assign in_keep  = ({1'b0, in_slave} < slave_count_q) && (int'(in_slave) < MAX_SLAVES);
  assign in_load  = in_hs & in_keep;
  assign in_cell  = CELL_AW'(int'(in_slave) * BLOCK_BYTES + int'(in_idx));
  assign in_slv   = SLV_AW'(in_slave);

  // update stage
  logic                  s1_valid_q;
  logic [SLV_AW-1:0]     s1_slave_q;
  logic [CELL_AW-1:0]    s1_cell_q;
  logic                  s1_idx_ok_q;
  logic                  s1_counts_q;
  logic [VAL_W-1:0]      s1_val_q;
  logic                  s1_last_q;
  logic                  byp_prev_q;
  logic                  byp_tot_q;
  logic                  byp_sat_q;
  logic [VAL_W-1:0]      byp_prev_val_q;
  logic [TOTAL_BITS-1:0] byp_tot_val_q;
  logic [EVENT_W-1:0]    byp_sat_val_q;
  logic                  byp_hp_val_q;

  logic                  hit_q;

  logic [VAL_W-1:0]      prev_rdata;
  logic [TOTAL_BITS-1:0] tot_rdata;
  logic [EVENT_W:0]      slv_rdata;

  logic                  adv;
  logic [VAL_W-1:0]      prev_cur;
  logic [TOTAL_BITS-1:0] tot_cur;
  logic [EVENT_W-1:0]    sat_cur;
  logic                  hp_cur;
  logic [DELTA_W-1:0]    delta;
  logic [TOTAL_BITS:0]   tot_sum;
  logic [TOTAL_BITS-1:0] tot_new;
  logic [VAL_W-1:0]      prev_new;
  logic                  hit_next;
  logic                  flagged;
  logic [EVENT_W-1:0]    sat_new;
  logic                  hp_new;

  logic                  m_valid_q;
  logic [DELTA_W-1:0]    m_delta_q;
  logic [OUT_W-1:0]      m_total_q;
  logic                  m_flag_q;
  logic [EVENT_W-1:0]    m_sat_q;

  assign adv           = s1_valid_q & (~m_valid_q | m_axis_tready);
  assign s_axis_tready = ~clr_busy_q & (~s1_valid_q | adv);

  always_comb begin
    prev_cur = byp_prev_q ? byp_prev_val_q : prev_rdata;
    tot_cur  = byp_tot_q  ? byp_tot_val_q  : tot_rdata;
    sat_cur  = byp_sat_q  ? byp_sat_val_q  : slv_rdata[EVENT_W-1:0];
    hp_cur   = byp_sat_q  ? byp_hp_val_q   : slv_rdata[EVENT_W];

    // a value below the stored one means the slave reset its counter
    if (!s1_counts_q) begin
      delta = '0;
    end else if (cor_q || !hp_cur || (s1_val_q < prev_cur)) begin
      delta = s1_val_q;
    end else begin
      delta = s1_val_q - prev_cur;
    end

    tot_sum  = {1'b0, tot_cur} + (TOTAL_BITS+1)'(delta);
    tot_new  = tot_sum[TOTAL_BITS] ? TOTAL_MAX : tot_sum[TOTAL_BITS-1:0];
    prev_new = cor_q ? '0 : s1_val_q;
    hit_next = hit_q | (s1_counts_q & (s1_val_q == FF_VALUE));
    flagged  = s1_last_q & hit_next;
    sat_new  = (flagged && (sat_cur != EVENT_MAX)) ? sat_cur + EVENT_W'(1) : sat_cur;
    hp_new   = s1_last_q ? ~cor_q : hp_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (in_hs) begin
        s1_valid_q <= in_keep;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        hit_q <= s1_last_q ? 1'b0 : hit_next;
      end
    end
  end

  // load the update stage, and forward the value being written when the next request hits the same entry
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_slave_q     <= in_slv;
      s1_cell_q      <= in_cell;
      s1_idx_ok_q    <= int'(in_idx) < BLOCK_BYTES;
      s1_counts_q    <= counts_errors(in_idx);
      s1_val_q       <= in_val;
      s1_last_q      <= s_axis_tlast;
      byp_prev_q     <= adv & s1_idx_ok_q & (s1_cell_q == in_cell);
      byp_tot_q      <= adv & s1_counts_q & (s1_cell_q == in_cell);
      byp_sat_q      <= adv & (s1_slave_q == in_slv);
      byp_prev_val_q <= prev_new;
      byp_tot_val_q  <= tot_new;
      byp_sat_val_q  <= sat_new;
      byp_hp_val_q   <= hp_new;
    end
  end

  ecda_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (adv & s1_idx_ok_q),
    .waddr_i (s1_cell_q),
    .wdata_i (prev_new),
    .re_i    (in_load),
    .raddr_i (in_cell),
    .rdata_o (prev_rdata)
  );

  ecda_ram #(
    .WIDTH (TOTAL_BITS),
    .DEPTH (CELLS)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (clr_busy_q | (adv & s1_counts_q)),
    .waddr_i (clr_busy_q ? clr_cnt_q : s1_cell_q),
    .wdata_i (clr_busy_q ? '0 : tot_new),
    .re_i    (in_load),
    .raddr_i (in_cell),
    .rdata_o (tot_rdata)
  );

  // per slave: previous-block mark above the flagged-block count
  ecda_ram #(
    .WIDTH (EVENT_W + 1),
    .DEPTH (MAX_SLAVES)
  ) u_event_ram (
    .clk_i   (clk_i),
    .we_i    ((clr_busy_q & (int'(clr_cnt_q) < MAX_SLAVES)) | adv),
    .waddr_i (clr_busy_q ? SLV_AW'(clr_cnt_q) : s1_slave_q),
    .wdata_i (clr_busy_q ? '0 : {hp_new, sat_new}),
    .re_i    (in_load),
    .raddr_i (in_slv),
    .rdata_o (slv_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_delta_q <= delta;
      m_total_q <= s1_counts_q ? OUT_W'(tot_new) : '0;
      m_flag_q  <= flagged;
      m_sat_q   <= sat_new;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, m_sat_q, m_flag_q, m_total_q,
                          m_delta_q};

endmodule

### src/ecda_checker.sv
// port-level checks of the error counter delta accumulator, bound to the top level
module ecda_checker
  import ecda_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [APB_AW-1:0]      paddr,
  input logic [APB_DW-1:0]      pwdata,
  input logic [APB_DW-1:0]      prdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a flagged block is always counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_FLAG_BIT] |-> m_axis_tdata[OUT_EVT_LSB +: EVENT_W] != '0)
    else $error("flagged block with zero event count");

  // s_axis_tready is low when reset has just been released, at the start of the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !s_axis_tready)
    else $error("request taken during clearing sweep");

  // the auto-clear mode bit reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (reg_e'(paddr[2]) == REG_AUTO_CLEAR)
    |=> (reg_e'(paddr[2]) != REG_AUTO_CLEAR) || (prdata[0] == $past(pwdata[0])))
    else $error("auto-clear readback mismatch");

endmodule

bind error_counter_delta_accumulator_top ecda_checker u_ecda_checker (.*);

### sim/tb.sv
// self-checking testbench for the error counter delta accumulator top level
module tb;
  import ecda_pkg::*;

  localparam int SLOTS = MAX_SLAVES_DEF * BLOCK_BYTES;

  typedef struct packed {
    logic [EVENT_W-1:0] events;
    logic               flag;
    logic [OUT_W-1:0]   total;
    logic [DELTA_W-1:0] delta;
  } result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tready = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // model of the accumulator state and its registers
  logic [VAL_W-1:0]   prev_val [SLOTS];
  bit                 written [SLOTS];
  logic [OUT_W-1:0]   run_total [SLOTS];
  bit                 has_prev [MAX_SLAVES_DEF];
  logic [EVENT_W-1:0] flagged_blocks [MAX_SLAVES_DEF];
  bit                 ff_seen = 1'b0;
  bit                 cor = 1'b0;
  logic [SCOUNT_W-1:0] n_slaves = SLAVE_COUNT_RST;

  result_t pending[$];

  int unsigned send_gap_pct = 23;
  int unsigned recv_stall_pct = 46;
  int unsigned errors = 0;
  int unsigned sent_count = 0;
  int unsigned ignored_count = 0;
  int unsigned checked_count = 0;
  int unsigned flagged_count = 0;
  int unsigned reg_writes = 0;

  error_counter_delta_accumulator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
             what, checked_count, got, want);
    errors++;
  endtask

  function automatic bit counter_byte(input logic [IDX_W-1:0] idx);
    return idx < BLOCK_BYTES && idx != IDX_STATUS_LO && idx != IDX_STATUS_HI;
  endfunction

  // true once every counter byte of the slave holds a stored value
  function automatic bit slave_primed(input int unsigned slave);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (counter_byte(IDX_W'(i)) && !written[slave * BLOCK_BYTES + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic accumulate_byte(input logic [SLAVE_W-1:0] slave, input logic [IDX_W-1:0] idx,
                                 input logic [VAL_W-1:0] val, input logic lst);
    result_t r;
    int unsigned slot;
    logic [OUT_W:0] sum;
    if (slave >= n_slaves) begin
      ignored_count++;
      return;
    end
    r = '0;
    if (idx < BLOCK_BYTES) begin
      slot = slave * BLOCK_BYTES + idx;
      if (counter_byte(idx)) begin
        if (val == FF_VALUE) ff_seen = 1'b1;
        if (cor || !has_prev[slave] || val < prev_val[slot]) begin
          r.delta = val;
        end else begin
          r.delta = val - prev_val[slot];
        end
        sum = {1'b0, run_total[slot]} + (OUT_W+1)'(r.delta);
        run_total[slot] = sum[OUT_W] ? '1 : sum[OUT_W-1:0];
        r.total = run_total[slot];
      end
      prev_val[slot] = cor ? '0 : val;
      written[slot] = 1'b1;
    end
    if (lst) begin
      has_prev[slave] = !cor;
      if (ff_seen) begin
        r.flag = 1'b1;
        flagged_count++;
        if (flagged_blocks[slave] != '1) flagged_blocks[slave]++;
      end
      ff_seen = 1'b0;
    end
    r.events = flagged_blocks[slave];
    pending.push_back(r);
  endtask

  task automatic send_byte(input logic [SLAVE_W-1:0] slave, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic lst);
    if ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_VAL_LSB - VAL_W){1'b0}}, val, idx, slave};
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    accumulate_byte(slave, idx, val, lst);
    sent_count++;
  endtask

  task automatic wait_idle();
    int unsigned n;
    s_tvalid <= 1'b0;
    n = 0;
    while (pending.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    // ignored requests give no result, so allow the pipeline to empty
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_reg(input reg_e r, input logic [APB_DW-1:0] v);
    logic [APB_DW-1:0] mask;
    wait_idle();
    mask = (r == REG_AUTO_CLEAR) ? 32'h1 : 32'h7F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (v & mask)) report("register readback", prdata, v & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_AUTO_CLEAR) begin
      cor = v[0];
    end else begin
      n_slaves = v[SCOUNT_W-1:0];
    end
    reg_writes++;
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
    result_t want;
    checked_count++;
    if (pending.size() == 0) begin
      report("unexpected result", d[31:0], 32'h0);
      return;
    end
    want = pending.pop_front();
    if (d[DELTA_W-1:0] !== want.delta)
      report("delta", 32'(d[DELTA_W-1:0]), 32'(want.delta));
    if (d[OUT_TOTAL_LSB +: OUT_W] !== want.total)
      report("total", d[OUT_TOTAL_LSB +: OUT_W], want.total);
    if (d[OUT_FLAG_BIT] !== want.flag)
      report("block_saturated", 32'(d[OUT_FLAG_BIT]), 32'(want.flag));
    if (d[OUT_EVT_LSB +: EVENT_W] !== want.events)
      report("saturation_events", d[OUT_EVT_LSB +: EVENT_W], want.events);
    if (d[OUT_TDATA_W-1:OUT_USED_W] !== '0)
      report("tdata padding", 32'(d[OUT_TDATA_W-1:OUT_USED_W]), 32'h0);
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_tready) check_result(m_axis_tdata);
  end

  function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] old_val);
    int unsigned sel;
    int unsigned grown;
    sel = $urandom_range(9);
    grown = old_val + $urandom_range(6);
    case (sel)
      0: return FF_VALUE;
      1: return '0;
      2, 3, 4, 5, 6: begin
        // mostly rising counters, sometimes a wrap that looks like a reset
        return (grown > 255) ? VAL_W'($urandom_range(20)) : VAL_W'(grown);
      end
      default: return VAL_W'($urandom_range(255));
    endcase
  endfunction

  task automatic test_extremes();
    send_byte(63, 0, 8'h00, 1'b0);
    send_byte(63, 1, FF_VALUE, 1'b0);
    send_byte(63, IDX_STATUS_LO, 8'hAA, 1'b0);
    send_byte(63, 31, 8'h55, 1'b0);
    send_byte(63, 19, 8'h80, 1'b1);
  endtask

  // rise, drop below the stored value, repeated offset, no 0xff in the block
  task automatic test_deltas();
    send_byte(63, 0, 8'h05, 1'b0);
    send_byte(63, 1, 8'h10, 1'b0);
    send_byte(63, 1, 8'h30, 1'b0);
    send_byte(63, IDX_STATUS_HI, 8'h01, 1'b0);
    send_byte(63, 19, 8'h80, 1'b1);
  endtask

  // the 0xff flag is shared between slaves up to the next last byte
  task automatic test_interleaved();
    send_byte(0, 3, FF_VALUE, 1'b0);
    send_byte(1, 2, 8'h07, 1'b1);
    send_byte(0, 3, 8'h01, 1'b1);
  endtask

  task automatic test_slave_range();
    set_reg(REG_SLAVE_COUNT, 32'd2);
    send_byte(2, 0, FF_VALUE, 1'b1);
    send_byte(63, 5, 8'h40, 1'b1);
    send_byte(1, 2, 8'h09, 1'b1);
    set_reg(REG_SLAVE_COUNT, 32'd0);
    send_byte(0, 0, 8'h01, 1'b1);
    set_reg(REG_SLAVE_COUNT, 32'd64);
  endtask

  // auto-clear also drops the previous-block mark of each slave that ends a block while it is on
  task automatic test_auto_clear();
    set_reg(REG_AUTO_CLEAR, 32'd1);
    send_byte(63, 0, 8'h03, 1'b0);
    send_byte(63, 1, FF_VALUE, 1'b0);
    send_byte(0, 3, 8'h07, 1'b1);
    send_byte(1, 2, 8'h00, 1'b1);
    send_byte(63, 19, 8'h01, 1'b1);
    set_reg(REG_AUTO_CLEAR, 32'd0);
  endtask

  task automatic test_random_phase(input int unsigned n_target, input int unsigned send_pct,
                                   input int unsigned recv_pct, input bit cor_v,
                                   input int unsigned count_v);
    int unsigned counted;
    int unsigned slave;
    int unsigned idx;
    int unsigned n_noise;
    logic lst;
    set_reg(REG_AUTO_CLEAR, 32'(cor_v));
    set_reg(REG_SLAVE_COUNT, count_v);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
    counted = 0;
    while (counted < n_target) begin
      if (n_slaves != 0 && $urandom_range(99) < 75) begin
        slave = $urandom_range(n_slaves - 1);
        for (int i = 0; i < BLOCK_BYTES; i++) begin
          send_byte(SLAVE_W'(slave), IDX_W'(i), pick_value(prev_val[slave * BLOCK_BYTES + i]),
                    i == BLOCK_BYTES - 1);
          counted++;
        end
      end else begin
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) begin
          slave = $urandom_range(MAX_SLAVES_DEF - 1);
          idx = $urandom_range(31);
          lst = ($urandom_range(3) == 0);
          // a block end must not leave stored values unset for later deltas
          if (!cor && !slave_primed(slave)) lst = 1'b0;
          send_byte(SLAVE_W'(slave), IDX_W'(idx), VAL_W'($urandom_range(255)), lst);
          if (slave < n_slaves) counted++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      prev_val[i] = '0;
      written[i] = 1'b0;
      run_total[i] = '0;
    end
    for (int i = 0; i < MAX_SLAVES_DEF; i++) begin
      has_prev[i] = 1'b0;
      flagged_blocks[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_deltas();
    test_interleaved();
    test_slave_range();
    test_auto_clear();
    test_random_phase(160, 23, 46, 1'b0, 64);
    test_random_phase(120, 46, 23, 1'b1, $urandom_range(1, 63));
    test_random_phase(180, 0, 0, 1'b0, $urandom_range(1, 64));
    wait_idle();
    if (pending.size() != 0) report("results never delivered", pending.size(), 32'h0);
    $display("covered %0d requests (%0d dropped for slave range), %0d results, %0d flagged blocks",
             sent_count, ignored_count, checked_count, flagged_count);
    $display("over %0d register writes with auto-clear on and off and several slave counts",
             reg_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("tb: failure");
    $finish;
  end

endmodule
